// ===== rtl/btha_pkg.sv =====
// ----------------------------------------------------------------------------
// btha_pkg
// Types, codes and constants shared by the boundary-tag heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package btha_pkg;

    localparam int HEAP_DEPTH_DEF = 4096;
    localparam int CAP_RESET      = 4096;
    localparam int CAP_MIN        = 68;
    localparam int THR_RESET      = 64;
    localparam int SZ_MIN         = 5;
    localparam int ELEM_SHIFT     = 3;

    localparam int ELEM_W = 33;
    localparam int IDX_W  = 14;
    localparam int CAP_W  = 13;
    localparam int THR_W  = 12;

    localparam logic [ELEM_W-1:0] TAG_HEAD = 33'h0CAFEFADE;
    localparam logic [ELEM_W-1:0] TAG_TAIL = 33'h0BEBEFADA;

    localparam logic REG_CAP = 1'b0;
    localparam logic REG_THR = 1'b1;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_INVALID   = 3'd3,
        ST_ALREADY   = 3'd4,
        ST_BAD_SIZE  = 3'd5,
        ST_BAD_TAGS  = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE    = 5'd0,
        OP_ACCEPT  = 5'd1,
        OP_RD_IDX  = 5'd2,
        OP_LD_HEAD = 5'd3,
        OP_ADV     = 5'd4,
        OP_RD_NX   = 5'd5,
        OP_MERGE   = 5'd6,
        OP_SB      = 5'd7,
        OP_SPLIT1  = 5'd8,
        OP_SPLIT2  = 5'd9,
        OP_COMMIT  = 5'd10,
        OP_FREE_WR = 5'd11,
        OP_COUNT   = 5'd12,
        OP_RD_T    = 5'd13,
        OP_RD_S    = 5'd14,
        OP_RB      = 5'd15,
        OP_CLR     = 5'd16
    } t_op;

    typedef struct packed {
        logic [1:0]  mode;
        logic [14:0] request_bytes;
        logic [11:0] block_offset;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [11:0] alloc_offset;
        logic [10:0] free_count;
        logic [15:0] free_bytes;
        logic [10:0] used_count;
        logic [15:0] used_bytes;
        logic [12:0] high_water;
        logic [31:0] alloc_total;
        logic [47:0] alloc_elems_total;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [1:0] step;
        logic       finish;
        t_status    status;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_lt5;
        logic rd_past;
        logic rd_neg;
        logic rd_ge_lim;
        logic rd_gt2;
        logic nx_add_past;
        logic rd_head;
        logic rd_tail;
        logic rd_trail;
        logic idx_lt_lim;
        logic nx_lt_lim;
        logic sz_lt_want;
        logic want_ge_lim;
        logic gt_thr;
        logic off_bad;
        logic raw_neg;
        logic out_busy;
        logic cap_wr;
        logic clr_last;
    } t_dp_flags;

endpackage

`default_nettype wire

// ===== rtl/btha_ram.sv =====
// ----------------------------------------------------------------------------
// btha_ram
// Generic simple dual-port RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module btha_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/btha_dpath.sv =====
// ----------------------------------------------------------------------------
// btha_dpath
// Heap store, walk registers, counters, register file and result register
// ----------------------------------------------------------------------------
`default_nettype none

module btha_dpath #(
    parameter int HEAP_DEPTH = btha_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire btha_pkg::t_dp_cmd    i_cmd,
    output btha_pkg::t_dp_flags       o_flags,
    input  wire btha_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output btha_pkg::t_out_item       o_out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata
);
    import btha_pkg::*;

    localparam int AW      = $clog2(HEAP_DEPTH);
    localparam int RST_CAP = (CAP_RESET < HEAP_DEPTH) ? CAP_RESET : HEAP_DEPTH;

    logic [CAP_W-1:0]  r_cap;
    logic [THR_W-1:0]  r_thr;
    logic [1:0]        r_mode;
    logic [CAP_W-1:0]  r_want;
    logic [11:0]       r_off;
    logic [IDX_W-1:0]  r_idx, r_nx, r_sz, r_at, r_bsz;
    logic              r_neg;
    logic [10:0]       r_nf, r_nu;
    logic [12:0]       r_sf, r_su;
    logic [12:0]       r_fill, n_fill;
    logic [31:0]       r_alloc, n_alloc;
    logic [47:0]       r_elems, n_elems;
    logic [AW-1:0]     r_clr;
    logic              r_ovalid;
    t_out_item         r_out;

    logic [ELEM_W-1:0] w_rd, w_mag, w_wdata;
    logic [CAP_W-1:0]  w_lim, w_cfg_cap;
    logic [IDX_W-1:0]  w_raddr, w_merge_sz, w_end;
    logic [31:0]       w_wa32;
    logic              w_wreq, w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;
    assign w_lim    = r_cap - CAP_W'(2);
    assign w_mag    = w_rd[ELEM_W-1] ? (~w_rd + ELEM_W'(1)) : w_rd;
    assign w_merge_sz = r_sz + w_rd[IDX_W-1:0];
    assign w_end    = r_idx + r_sz;
    assign prdata   = (paddr[2] == REG_THR) ? 32'(r_thr) : 32'(r_cap);

    always_comb begin
        w_cfg_cap = pwdata[CAP_W-1:0];
        if (w_cfg_cap < CAP_W'(CAP_MIN)) begin
            w_cfg_cap = CAP_W'(CAP_MIN);
        end else if (32'(w_cfg_cap) > 32'(HEAP_DEPTH)) begin
            w_cfg_cap = CAP_W'(HEAP_DEPTH);
        end
    end

    // status towards the controller
    always_comb begin
        o_flags.rd_lt5      = w_mag < ELEM_W'(SZ_MIN);
        o_flags.rd_past     = (34'(r_idx) + 34'(w_mag)) > 34'(r_cap);
        o_flags.rd_neg      = w_rd[ELEM_W-1];
        o_flags.rd_ge_lim   = w_mag >= ELEM_W'(w_lim);
        o_flags.rd_gt2      = !w_rd[ELEM_W-1] && (w_rd > ELEM_W'(2));
        o_flags.nx_add_past = (34'(r_nx) + 34'(w_rd)) > 34'(r_cap);
        o_flags.rd_head     = w_rd == TAG_HEAD;
        o_flags.rd_tail     = w_rd == TAG_TAIL;
        o_flags.rd_trail    = w_rd == ELEM_W'(r_sz);
        o_flags.idx_lt_lim  = r_idx < IDX_W'(w_lim);
        o_flags.nx_lt_lim   = r_nx < IDX_W'(w_lim);
        o_flags.sz_lt_want  = r_sz < IDX_W'(r_want);
        o_flags.want_ge_lim = r_want >= w_lim;
        o_flags.gt_thr      = (r_sz - IDX_W'(r_want)) > IDX_W'(r_thr);
        o_flags.off_bad     = (r_off < 12'd2) || (CAP_W'(r_off) >= r_cap);
        o_flags.raw_neg     = r_neg;
        o_flags.out_busy    = r_ovalid && i_out_stall;
        o_flags.cap_wr      = w_cfg_wr && (paddr[2] == REG_CAP);
        o_flags.clr_last    = 32'(r_clr) == 32'(HEAP_DEPTH - 1);
    end

    // read address
    always_comb begin
        case (i_cmd.op)
            OP_LD_HEAD: w_raddr = r_idx + IDX_W'(1);
            OP_RD_NX:   w_raddr = r_nx;
            OP_RD_T:    w_raddr = w_end - IDX_W'(2);
            OP_RD_S:    w_raddr = w_end - IDX_W'(1);
            default:    w_raddr = r_idx;
        endcase
    end

    // write port
    always_comb begin
        w_wreq  = 1'b1;
        w_wa32  = 32'(r_idx);
        w_wdata = '0;
        case (i_cmd.op)
            OP_SB: begin
                case (i_cmd.step)
                    2'd0: begin
                        w_wa32  = 32'(r_at);
                        w_wdata = ELEM_W'(r_bsz);
                    end
                    2'd1: begin
                        w_wa32  = 32'(r_at + IDX_W'(1));
                        w_wdata = TAG_HEAD;
                    end
                    2'd2: begin
                        w_wa32  = 32'(r_at + r_bsz - IDX_W'(2));
                        w_wdata = TAG_TAIL;
                    end
                    default: begin
                        w_wa32  = 32'(r_at + r_bsz - IDX_W'(1));
                        w_wdata = ELEM_W'(r_bsz);
                    end
                endcase
            end
            OP_RB: begin
                case (i_cmd.step)
                    2'd0: begin
                        w_wa32  = 32'(w_lim);
                        w_wdata = TAG_TAIL;
                    end
                    2'd1: begin
                        w_wa32  = 32'(r_cap - CAP_W'(1));
                        w_wdata = ELEM_W'(r_cap);
                    end
                    2'd2: begin
                        w_wa32  = 32'd0;
                        w_wdata = ELEM_W'(r_cap);
                    end
                    default: begin
                        w_wa32  = 32'd1;
                        w_wdata = TAG_HEAD;
                    end
                endcase
            end
            OP_COMMIT: begin
                w_wdata = ~ELEM_W'(r_sz) + ELEM_W'(1);
            end
            OP_FREE_WR: begin
                w_wdata = ELEM_W'(r_sz);
            end
            OP_CLR: begin
                w_wa32 = 32'(r_clr);
                if (w_wa32 == 32'd0 || w_wa32 == 32'(RST_CAP - 1)) begin
                    w_wdata = ELEM_W'(RST_CAP);
                end else if (w_wa32 == 32'd1) begin
                    w_wdata = TAG_HEAD;
                end else if (w_wa32 == 32'(RST_CAP - 2)) begin
                    w_wdata = TAG_TAIL;
                end
            end
            default: begin
                w_wreq = 1'b0;
            end
        endcase
    end

    btha_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (HEAP_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wreq && (w_wa32 < 32'(HEAP_DEPTH))),
        .i_waddr (w_wa32[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (AW'(32'(w_raddr))),
        .o_rdata (w_rd)
    );

    // statistics
    always_comb begin
        n_fill  = r_fill;
        n_alloc = r_alloc;
        n_elems = r_elems;
        if (i_cmd.op == OP_COMMIT) begin
            n_alloc = r_alloc + 32'd1;
            n_elems = r_elems + 48'(r_sz);
            if (w_end > IDX_W'(r_fill)) begin
                n_fill = 13'(w_end);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_W'(RST_CAP);
            r_thr    <= THR_W'(THR_RESET);
            r_fill   <= '0;
            r_alloc  <= '0;
            r_elems  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_alloc  <= n_alloc;
            r_elems  <= n_elems;
            if (w_cfg_wr) begin
                if (paddr[2] == REG_CAP) begin
                    r_cap   <= w_cfg_cap;
                    r_fill  <= '0;
                    r_alloc <= '0;
                    r_elems <= '0;
                end else begin
                    r_thr <= pwdata[THR_W-1:0];
                end
            end
            if (i_cmd.op == OP_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            r_ovalid <= i_cmd.finish || (r_ovalid && i_out_stall);
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_mode <= i_in_data.mode;
                r_want <= CAP_W'((16'(i_in_data.request_bytes) + 16'd7) >> ELEM_SHIFT)
                          + CAP_W'(4);
                r_off  <= i_in_data.block_offset;
                r_idx  <= (i_in_data.mode == MODE_FREE) ?
                          (IDX_W'(i_in_data.block_offset) - IDX_W'(2)) : '0;
                r_nf   <= '0;
                r_nu   <= '0;
                r_sf   <= '0;
                r_su   <= '0;
            end
            OP_LD_HEAD: begin
                r_neg <= w_rd[ELEM_W-1];
                r_sz  <= w_mag[IDX_W-1:0];
                r_nx  <= r_idx + w_mag[IDX_W-1:0];
            end
            OP_ADV: begin
                r_idx <= r_nx;
            end
            OP_MERGE: begin
                r_sz  <= w_merge_sz;
                r_nx  <= r_idx + w_merge_sz;
                r_at  <= r_idx;
                r_bsz <= w_merge_sz;
            end
            OP_SPLIT1: begin
                r_at  <= r_idx;
                r_bsz <= IDX_W'(r_want);
            end
            OP_SPLIT2: begin
                r_at  <= r_idx + IDX_W'(r_want);
                r_bsz <= r_sz - IDX_W'(r_want);
                r_sz  <= IDX_W'(r_want);
            end
            OP_COUNT: begin
                r_idx <= r_nx;
                if (r_neg) begin
                    r_nu <= r_nu + 11'd1;
                    r_su <= r_su + 13'(r_sz - IDX_W'(4));
                end else begin
                    r_nf <= r_nf + 11'd1;
                    r_sf <= r_sf + 13'(r_sz - IDX_W'(4));
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.status            <= i_cmd.status;
            r_out.alloc_offset      <= '0;
            r_out.free_count        <= '0;
            r_out.free_bytes        <= '0;
            r_out.used_count        <= '0;
            r_out.used_bytes        <= '0;
            r_out.high_water        <= n_fill;
            r_out.alloc_total       <= n_alloc;
            r_out.alloc_elems_total <= n_elems;
            if (i_cmd.status == ST_OK && r_mode == MODE_ALLOC) begin
                r_out.alloc_offset <= 12'(r_idx + IDX_W'(2));
            end
            if (i_cmd.status == ST_OK && r_mode == MODE_CHECK) begin
                r_out.free_count <= r_nf;
                r_out.free_bytes <= {r_sf, 3'b000};
                r_out.used_count <= r_nu;
                r_out.used_bytes <= {r_su, 3'b000};
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/btha_ctrl.sv =====
// ----------------------------------------------------------------------------
// btha_ctrl
// Sequencer for allocate, free and check walks, store clearing and rebuild
// ----------------------------------------------------------------------------
`default_nettype none

module btha_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [1:0]          i_in_mode,
    output logic                     o_in_stall,
    input  wire btha_pkg::t_dp_flags i_flags,
    output btha_pkg::t_dp_cmd        o_cmd
);
    import btha_pkg::*;

    typedef enum logic [21:0] {
        S_CLEAR    = 22'h000001,
        S_IDLE     = 22'h000002,
        S_NOP      = 22'h000004,
        S_A_LOOP   = 22'h000008,
        S_A_HEAD   = 22'h000010,
        S_A_ADV    = 22'h000020,
        S_A_MCHK   = 22'h000040,
        S_A_MRD    = 22'h000080,
        S_A_FIT    = 22'h000100,
        S_SETBLK   = 22'h000200,
        S_A_SPLIT2 = 22'h000400,
        S_A_COMMIT = 22'h000800,
        S_F_START  = 22'h001000,
        S_F_HEAD   = 22'h002000,
        S_F_HCHK   = 22'h004000,
        S_F_TCHK   = 22'h008000,
        S_F_SCHK   = 22'h010000,
        S_C_LOOP   = 22'h020000,
        S_C_HEAD   = 22'h040000,
        S_C_HCHK   = 22'h080000,
        S_C_TCHK   = 22'h100000,
        S_C_SCHK   = 22'h200000
    } t_state;

    t_state     r_state, n_state, r_ret, n_ret;
    logic [1:0] r_step, n_step, r_rb_step, n_rb_step;
    logic       r_rb_act, n_rb_act;

    assign o_in_stall = !(r_state == S_IDLE && !r_rb_act && !i_flags.out_busy);

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_step    = r_step;
        n_rb_act  = r_rb_act;
        n_rb_step = r_rb_step;
        o_cmd     = '{op: OP_NONE, step: 2'd0, finish: 1'b0, status: ST_OK};

        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLR;
                if (i_flags.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_rb_act) begin
                    o_cmd.op   = OP_RB;
                    o_cmd.step = r_rb_step;
                    n_rb_step  = r_rb_step + 2'd1;
                    n_rb_act   = r_rb_step != 2'd3;
                end else if (i_in_valid && !i_flags.out_busy) begin
                    o_cmd.op = OP_ACCEPT;
                    case (i_in_mode)
                        MODE_ALLOC: n_state = S_A_LOOP;
                        MODE_FREE:  n_state = S_F_START;
                        MODE_CHECK: n_state = S_C_LOOP;
                        default:    n_state = S_NOP;
                    endcase
                end
            end
            S_NOP: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_A_LOOP: begin
                if (i_flags.want_ge_lim) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_TOO_LARGE;
                    n_state      = S_IDLE;
                end else if (i_flags.idx_lt_lim) begin
                    o_cmd.op = OP_RD_IDX;
                    n_state  = S_A_HEAD;
                end else begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_NO_FIT;
                    n_state      = S_IDLE;
                end
            end
            S_A_HEAD: begin
                o_cmd.op = OP_LD_HEAD;
                if (i_flags.rd_lt5 || i_flags.rd_past) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_NO_FIT;
                    n_state      = S_IDLE;
                end else if (i_flags.rd_neg) begin
                    n_state = S_A_ADV;
                end else begin
                    n_state = S_A_MCHK;
                end
            end
            S_A_ADV: begin
                o_cmd.op = OP_ADV;
                n_state  = S_A_LOOP;
            end
            S_A_MCHK: begin
                if (i_flags.nx_lt_lim && i_flags.sz_lt_want) begin
                    o_cmd.op = OP_RD_NX;
                    n_state  = S_A_MRD;
                end else begin
                    n_state = S_A_FIT;
                end
            end
            S_A_MRD: begin
                if (i_flags.rd_gt2 && !i_flags.nx_add_past) begin
                    o_cmd.op = OP_MERGE;
                    n_ret    = S_A_MCHK;
                    n_state  = S_SETBLK;
                end else begin
                    n_state = S_A_FIT;
                end
            end
            S_A_FIT: begin
                if (!i_flags.sz_lt_want) begin
                    if (i_flags.gt_thr) begin
                        o_cmd.op = OP_SPLIT1;
                        n_ret    = S_A_SPLIT2;
                        n_state  = S_SETBLK;
                    end else begin
                        n_state = S_A_COMMIT;
                    end
                end else begin
                    o_cmd.op = OP_ADV;
                    n_state  = S_A_LOOP;
                end
            end
            S_SETBLK: begin
                o_cmd.op   = OP_SB;
                o_cmd.step = r_step;
                n_step     = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = r_ret;
                end
            end
            S_A_SPLIT2: begin
                o_cmd.op = OP_SPLIT2;
                n_ret    = S_A_COMMIT;
                n_state  = S_SETBLK;
            end
            S_A_COMMIT: begin
                o_cmd.op     = OP_COMMIT;
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_F_START: begin
                if (i_flags.off_bad) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_INVALID;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = OP_RD_IDX;
                    n_state  = S_F_HEAD;
                end
            end
            S_F_HEAD: begin
                o_cmd.op = OP_LD_HEAD;
                if (i_flags.rd_lt5 || i_flags.rd_ge_lim || i_flags.rd_past) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_INVALID;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_F_HCHK;
                end
            end
            S_F_HCHK: begin
                if (!i_flags.rd_head) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_INVALID;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = OP_RD_T;
                    n_state  = S_F_TCHK;
                end
            end
            S_F_TCHK: begin
                if (!i_flags.rd_tail) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_INVALID;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = OP_RD_S;
                    n_state  = S_F_SCHK;
                end
            end
            S_F_SCHK: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
                if (!i_flags.rd_trail) begin
                    o_cmd.status = ST_INVALID;
                end else if (!i_flags.raw_neg) begin
                    o_cmd.status = ST_ALREADY;
                end else begin
                    o_cmd.op = OP_FREE_WR;
                end
            end
            S_C_LOOP: begin
                if (i_flags.idx_lt_lim) begin
                    o_cmd.op = OP_RD_IDX;
                    n_state  = S_C_HEAD;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_C_HEAD: begin
                o_cmd.op = OP_LD_HEAD;
                if (i_flags.rd_lt5) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BAD_SIZE;
                    n_state      = S_IDLE;
                end else if (i_flags.rd_past) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BAD_TAGS;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_C_HCHK;
                end
            end
            S_C_HCHK: begin
                if (!i_flags.rd_head) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BAD_TAGS;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = OP_RD_T;
                    n_state  = S_C_TCHK;
                end
            end
            S_C_TCHK: begin
                if (!i_flags.rd_tail) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BAD_TAGS;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = OP_RD_S;
                    n_state  = S_C_SCHK;
                end
            end
            S_C_SCHK: begin
                if (!i_flags.rd_trail) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_BAD_TAGS;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.op = OP_COUNT;
                    n_state  = S_C_LOOP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a capacity write restarts the rebuild with the new value
        if (i_flags.cap_wr) begin
            n_rb_act  = 1'b1;
            n_rb_step = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ret     <= S_IDLE;
            r_step    <= 2'd0;
            r_rb_act  <= 1'b0;
            r_rb_step <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_step    <= n_step;
            r_rb_act  <= n_rb_act;
            r_rb_step <= n_rb_step;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/boundary_tag_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_core
// First-fit boundary-tag heap allocator with free and whole-heap check
//
//   channel   direction   handshake                        payload
//   in        input       i_in_valid / o_in_stall          i_in_data  (t_in_item)
//   out       output      o_out_valid / i_out_stall        o_out_data (t_out_item)
//   cfg       input       psel penable pwrite / pready     paddr pwdata prdata
//
// One item at a time. Allocate walks blocks from the heap start, skips blocks
// in use, merges a too-small free block with the free blocks after it, and splits
// it if the rest exceeds the threshold before the commit; check walks every block;
// free tests one block's size and tags. All walks share the single store read port.
// After reset a clearing pass writes every store entry before the first beat
// is taken; a capacity write adds a rebuild of the heap tags.
// A result beat waits in its register; the next beat is taken as it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_heap_allocator_core #(
    parameter int HEAP_DEPTH = btha_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire btha_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output btha_pkg::t_out_item       o_out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import btha_pkg::*;

    t_dp_cmd   w_cmd;
    t_dp_flags w_flags;

    assign pready = 1'b1;

    btha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_data.mode),
        .o_in_stall (o_in_stall),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd)
    );

    btha_dpath #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_flags     (w_flags),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb_boundary_tag_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_boundary_tag_heap_allocator_core
// Self-checking bench for the boundary-tag heap allocator. A directed table
// covers the allocate and free error codes, merging and the unused mode.
// Random phases follow, each with its own capacity and split threshold.
// Every accepted beat runs through a behavioural heap model in the bench, and
// each result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_boundary_tag_heap_allocator_core;
    import btha_pkg::*;

    localparam int DEPTH    = 4096;
    localparam int WD_LIMIT = 60000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    boundary_tag_heap_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // heap model state
    logic signed [ELEM_W-1:0] heap_mdl [DEPTH];
    longint      cap_mdl;
    longint      thr_mdl;
    logic [12:0] fill_mdl;
    logic [31:0] nalloc_mdl;
    logic [47:0] nelem_mdl;

    t_out_item   pending_results [$];
    int          live_offsets [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          out_burst = 1'b0;
    bit          in_burst = 1'b0;
    int          stall_left = 0;

    function automatic longint heap_rd(longint i);
        if (i < 0 || i >= DEPTH) return 0;
        return longint'(heap_mdl[i]);
    endfunction

    function automatic void heap_wr(longint i, longint v);
        if (i >= 0 && i < DEPTH) heap_mdl[i] = v[ELEM_W-1:0];
    endfunction

    function automatic void put_block(longint at, longint sz);
        heap_wr(at, sz);
        heap_wr(at + 1, longint'(TAG_HEAD));
        heap_wr(at + sz - 2, longint'(TAG_TAIL));
        heap_wr(at + sz - 1, sz);
    endfunction

    function automatic void rebuild_heap();
        put_block(0, cap_mdl);
        fill_mdl   = '0;
        nalloc_mdl = '0;
        nelem_mdl  = '0;
    endfunction

    function automatic void alloc_mdl(input logic [14:0] bytes, inout t_out_item r);
        longint lim, want, idx, raw, sz, nx, add;
        lim  = cap_mdl - 2;
        want = (longint'(bytes) + 7) / 8 + 4;
        idx  = 0;
        if (want >= lim) begin
            r.status = ST_TOO_LARGE;
            return;
        end
        r.status = ST_NO_FIT;
        while (idx < lim) begin
            raw = heap_rd(idx);
            sz  = raw < 0 ? -raw : raw;
            if (sz < SZ_MIN || idx + sz > cap_mdl) break;
            if (raw < 0) begin
                idx += sz;
                continue;
            end
            nx = idx + sz;
            while (nx < lim && heap_rd(nx) > 2 && sz < want) begin
                add = heap_rd(nx);
                if (nx + add > cap_mdl) break;
                sz += add;
                nx = idx + sz;
                put_block(idx, sz);
            end
            if (want <= sz) begin
                if (sz - want > thr_mdl) begin
                    put_block(idx, want);
                    put_block(idx + want, sz - want);
                    sz = want;
                end
                heap_wr(idx, -sz);
                nalloc_mdl += 1;
                nelem_mdl  += sz[47:0];
                if (idx + sz > longint'(fill_mdl)) fill_mdl = 13'(idx + sz);
                r.status       = ST_OK;
                r.alloc_offset = 12'(idx + 2);
                return;
            end
            idx += sz;
        end
    endfunction

    function automatic void free_mdl(input logic [11:0] off, inout t_out_item r);
        longint b, st, raw, sz;
        b = longint'(off);
        if (b < 2 || b >= cap_mdl) begin
            r.status = ST_INVALID;
            return;
        end
        st  = b - 2;
        raw = heap_rd(st);
        sz  = raw < 0 ? -raw : raw;
        if (heap_rd(st + 1) != longint'(TAG_HEAD) || sz < SZ_MIN || sz >= cap_mdl - 2 ||
            st + sz > cap_mdl || heap_rd(st + sz - 2) != longint'(TAG_TAIL) ||
            heap_rd(st + sz - 1) != sz) begin
            r.status = ST_INVALID;
            return;
        end
        if (raw >= 0) begin
            r.status = ST_ALREADY;
            return;
        end
        heap_wr(st, sz);
        r.status = ST_OK;
    endfunction

    function automatic void check_mdl(inout t_out_item r);
        longint idx, raw, sz, nf, nu, sf, su;
        idx = 0; nf = 0; nu = 0; sf = 0; su = 0;
        while (idx < cap_mdl - 2) begin
            raw = heap_rd(idx);
            sz  = raw < 0 ? -raw : raw;
            if (sz < SZ_MIN) begin
                r.status = ST_BAD_SIZE;
                return;
            end
            if (idx + sz > cap_mdl || heap_rd(idx + 1) != longint'(TAG_HEAD) ||
                heap_rd(idx + sz - 2) != longint'(TAG_TAIL) ||
                heap_rd(idx + sz - 1) != sz) begin
                r.status = ST_BAD_TAGS;
                return;
            end
            if (raw > 0) begin
                nf += 1;
                sf += sz - 4;
            end else begin
                nu += 1;
                su += sz - 4;
            end
            idx += sz;
        end
        r.status     = ST_OK;
        r.free_count = 11'(nf);
        r.free_bytes = 16'(sf * 8);
        r.used_count = 11'(nu);
        r.used_bytes = 16'(su * 8);
    endfunction

    function automatic t_out_item heap_step(t_in_item it);
        t_out_item r;
        r = '0;
        r.status = ST_OK;
        case (t_mode'(it.mode))
            MODE_ALLOC: alloc_mdl(it.request_bytes, r);
            MODE_FREE:  free_mdl(it.block_offset, r);
            MODE_CHECK: check_mdl(r);
            default: ;
        endcase
        r.high_water        = fill_mdl;
        r.alloc_total       = nalloc_mdl;
        r.alloc_elems_total = nelem_mdl;
        return r;
    endfunction

    task automatic send_beat(input t_in_item it);
        t_out_item r;
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        r = heap_step(it);
        pending_results.push_back(r);
        if (t_mode'(it.mode) == MODE_ALLOC && r.status == ST_OK)
            live_offsets.push_back(int'(r.alloc_offset));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic reg_sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (reg_sel == REG_THR) ? 3'd4 : 3'd0;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (reg_sel == REG_CAP) begin
            cap_mdl = longint'(val[12:0]);
            if (cap_mdl < CAP_MIN) cap_mdl = CAP_MIN;
            if (cap_mdl > DEPTH) cap_mdl = DEPTH;
            rebuild_heap();
            live_offsets.delete();
        end else begin
            thr_mdl = longint'(val[11:0]);
        end
    endtask

    // result side: random stall per beat
    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.alloc_offset !== want.alloc_offset ||
                    o_out_data.free_count !== want.free_count ||
                    o_out_data.free_bytes !== want.free_bytes ||
                    o_out_data.used_count !== want.used_count ||
                    o_out_data.used_bytes !== want.used_bytes ||
                    o_out_data.high_water !== want.high_water ||
                    o_out_data.alloc_total !== want.alloc_total ||
                    o_out_data.alloc_elems_total !== want.alloc_elems_total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, o_out_data);
                end
            end
            stall_left = out_burst ? 0 : $urandom_range(0, 15);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel ||
            !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("boundary_tag_heap_allocator_core test failed");
            $finish;
        end
    end

    typedef struct {
        t_mode   mode;
        int      req;
        int      off;
        bit      known;
        t_status st;
    } t_row;

    t_row directed [17] = '{
        '{MODE_CHECK, 0,     0,    1'b1, ST_OK},
        '{MODE_ALLOC, 1,     0,    1'b1, ST_OK},
        '{MODE_ALLOC, 32767, 0,    1'b1, ST_TOO_LARGE},
        '{MODE_ALLOC, 16,    0,    1'b1, ST_OK},
        '{MODE_FREE,  0,     0,    1'b1, ST_INVALID},
        '{MODE_FREE,  0,     4095, 1'b1, ST_INVALID},
        '{MODE_FREE,  0,     7,    1'b1, ST_OK},
        '{MODE_FREE,  0,     7,    1'b1, ST_ALREADY},
        '{MODE_FREE,  0,     3,    1'b1, ST_INVALID},
        '{MODE_CHECK, 0,     0,    1'b0, ST_OK},
        '{MODE_NONE,  0,     0,    1'b1, ST_OK},
        '{MODE_ALLOC, 32000, 0,    1'b0, ST_OK},
        '{MODE_ALLOC, 200,   0,    1'b0, ST_OK},
        '{MODE_FREE,  0,     2,    1'b1, ST_OK},
        '{MODE_ALLOC, 0,     0,    1'b0, ST_OK},
        '{MODE_CHECK, 0,     0,    1'b0, ST_OK},
        '{MODE_ALLOC, 8,     0,    1'b1, ST_NO_FIT}
    };

    initial begin
        t_in_item it;
        int r;
        int pick;
        logic [31:0] caps [8];
        logic [31:0] thrs [8];

        for (int i = 0; i < DEPTH; i++) heap_mdl[i] = '0;
        cap_mdl = CAP_RESET;
        thr_mdl = THR_RESET;
        rebuild_heap();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            it = '0;
            it.mode          = directed[k].mode;
            it.request_bytes = 15'(directed[k].req);
            it.block_offset  = 12'(directed[k].off);
            send_beat(it);
            if (directed[k].known && pending_results[$].status != directed[k].st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: status expected %s predicted %s", k,
                             directed[k].st.name(), pending_results[$].status.name());
            end
        end
        drain();

        caps = '{32'd68, 32'd4096, 32'd0, 32'hFFFF_FFFF, $urandom, $urandom_range(68, 600),
                 $urandom_range(68, 4096), 32'd100};
        thrs = '{32'd0, 32'd4095, 32'd64, 32'd0, $urandom, $urandom_range(0, 16),
                 $urandom_range(0, 200), 32'hFFFF_FFFF};
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_CAP, caps[ph]);
            reg_write(REG_THR, thrs[ph]);
            in_burst  = (ph % 3 == 1);
            out_burst = (ph % 4 == 2);
            for (int n = 0; n < 185; n++) begin
                it = t_in_item'({$urandom, $urandom});
                r  = $urandom_range(0, 99);
                if (r < 45) begin
                    it.mode = MODE_ALLOC;
                    if ($urandom_range(0, 99) < 85)
                        it.request_bytes = 15'($urandom_range(0, 300));
                end else if (r < 80) begin
                    it.mode = MODE_FREE;
                    if (live_offsets.size() != 0 && $urandom_range(0, 99) < 85) begin
                        pick = $urandom_range(0, live_offsets.size() - 1);
                        it.block_offset = 12'(live_offsets[pick]);
                        live_offsets.delete(pick);
                    end
                end else if (r < 95) begin
                    it.mode = MODE_CHECK;
                end else begin
                    it.mode = MODE_NONE;
                end
                send_beat(it);
            end
            drain();
        end

        if (mismatches == 0)
            $display("boundary_tag_heap_allocator_core test passed");
        else
            $display("boundary_tag_heap_allocator_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/btha_pkg.sv
rtl/btha_ram.sv
rtl/btha_dpath.sv
rtl/btha_ctrl.sv
rtl/boundary_tag_heap_allocator_core.sv
sim/tb_boundary_tag_heap_allocator_core.sv
